// ===== hdl/gotb_pkg.sv =====
package gotb_pkg;

    localparam int NUM_GROUPS     = 64;
    localparam int NUM_PARTITIONS = 16;

    localparam int GRP_IDX_W = $clog2(NUM_GROUPS);
    localparam int PART_W    = $clog2(NUM_PARTITIONS);

    localparam logic [8:0] GRP_LIMIT  = 9'(NUM_GROUPS);
    localparam logic [8:0] PART_LIMIT = 9'(NUM_PARTITIONS);

    localparam logic [1:0] OP_ASSIGN  = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CHECK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_PERM  = 2'd2;

    typedef struct packed {
        logic load;
        logic read;
        logic exec;
    } gotb_cmd_t;

endpackage

// ===== hdl/group_ownership_table.sv =====
// Ownership table of device groups. A request is taken when start is high while busy is low;
// it then goes through latch, table read, and decide and write back, with busy high until
// done, so a new request is taken only once the previous one is through. The status appears on
// status for one cycle with done high, in the same cycle in which busy falls, and must be
// captured then since it cannot be held off. The owner store is a single-port memory read
// in its own step. All entries read as free right after reset, with no clearing time.
module group_ownership_table
    import gotb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] req_type,
    input  logic [7:0] group_num,
    input  logic [7:0] partition_num,
    output logic       done,
    output logic [1:0] status
);

    gotb_cmd_t cmd;

    gotb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    gotb_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .req_type      (req_type),
        .group_num     (group_num),
        .partition_num (partition_num),
        .done          (done),
        .status        (status)
    );

endmodule

// ===== hdl/gotb_ctrl.sv =====
module gotb_ctrl
    import gotb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output gotb_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/gotb_datapath.sv =====
module gotb_datapath
    import gotb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  gotb_cmd_t  cmd,
    input  logic [1:0] req_type,
    input  logic [7:0] group_num,
    input  logic [7:0] partition_num,
    output logic       done,
    output logic [1:0] status
);

    logic [PART_W-1:0]    owner_mem [NUM_GROUPS];
    logic [NUM_GROUPS-1:0] flags_reg;

    logic [1:0]           op_reg;
    logic [GRP_IDX_W-1:0] grp_reg;
    logic [7:0]           part_reg;
    logic                 inval_reg;
    logic [PART_W-1:0]    owner_rd_reg;
    logic                 taken_reg;
    logic                 done_reg;
    logic [1:0]           status_reg;

    logic                 inval_next;
    logic                 mine;
    logic [1:0]           status_next;
    logic                 wr_take;
    logic                 wr_free;

    assign inval_next = (group_num == 8'd0) || ({1'b0, group_num} >= GRP_LIMIT) ||
                        (partition_num == 8'd0) || ({1'b0, partition_num} >= PART_LIMIT) ||
                        (req_type != OP_ASSIGN && req_type != OP_RELEASE &&
                         req_type != OP_CHECK);

    assign mine = taken_reg && (8'(owner_rd_reg) == part_reg);

    always_comb
    begin
        status_next = ST_INVAL;
        wr_take     = 1'b0;
        wr_free     = 1'b0;
        if (!inval_reg)
        begin
            unique case (op_reg)
                OP_ASSIGN:
                begin
                    if (mine)
                    begin
                        status_next = ST_OK;
                    end
                    else if (taken_reg)
                    begin
                        status_next = ST_PERM;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        wr_take     = 1'b1;
                    end
                end
                OP_RELEASE:
                begin
                    status_next = mine ? ST_OK : ST_PERM;
                    wr_free     = mine;
                end
                default:
                begin
                    status_next = mine ? ST_OK : ST_PERM;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= req_type;
            grp_reg   <= group_num[GRP_IDX_W-1:0];
            part_reg  <= partition_num;
            inval_reg <= inval_next;
        end
        if (cmd.read)
        begin
            owner_rd_reg <= owner_mem[grp_reg];
        end
        if (cmd.exec && (wr_take || wr_free))
        begin
            owner_mem[grp_reg] <= wr_take ? part_reg[PART_W-1:0] : '0;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            taken_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cmd.read)
            begin
                taken_reg <= flags_reg[grp_reg];
            end
            if (cmd.exec && (wr_take || wr_free))
            begin
                flags_reg[grp_reg] <= wr_take;
            end
        end
    end

    assign done   = done_reg;
    assign status = status_reg;

endmodule

// ===== bench/group_ownership_table_test.sv =====
`timescale 1ns / 100ps

module group_ownership_table_test;
    import gotb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1525;
    localparam int CALM_TAIL    = 200;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] grp;
        logic [7:0] part;
        bit         typed;
        logic [1:0] want;
    } probe_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] grp;
        logic [7:0] part;
        logic [1:0] status;
    } awaited_t;

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       start         = 1'b0;
    logic [1:0] req_type      = '0;
    logic [7:0] group_num     = '0;
    logic [7:0] partition_num = '0;
    logic       busy;
    logic       done;
    logic [1:0] status;

    probe_t     probes[$];
    awaited_t   awaited_status[$];

    bit              grp_taken[NUM_GROUPS];
    logic [PART_W-1:0] grp_owner[NUM_GROUPS];

    int  total_items;
    int  issued_count   = 0;
    int  accepted_count = 0;
    int  cycle_count    = 0;
    int  error_count    = 0;
    int  idle_left      = 0;
    int  drain_count    = 0;
    bit  run_over       = 1'b0;
    bit  timed_out      = 1'b0;
    bit  cur_typed      = 1'b0;
    logic [1:0] cur_want = '0;

    group_ownership_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .group_num     (group_num),
        .partition_num (partition_num),
        .done          (done),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void add_probe(logic [1:0] op, logic [7:0] grp, logic [7:0] part,
                                      bit typed, logic [1:0] want);
        probe_t p;
        p.op    = op;
        p.grp   = grp;
        p.part  = part;
        p.typed = typed;
        p.want  = want;
        probes.push_back(p);
    endfunction

    // Applies one request to the shadow table and returns the status it earns.
    function automatic logic [1:0] ownership_verdict(logic [1:0] op, logic [7:0] grp,
                                                     logic [7:0] part);
        bit taken;
        bit mine;
        if (grp == 0 || int'(grp) >= NUM_GROUPS || part == 0 ||
            int'(part) >= NUM_PARTITIONS || op == OP_UNUSED)
            return ST_INVAL;
        taken = grp_taken[grp[GRP_IDX_W-1:0]];
        mine  = taken && (int'(grp_owner[grp[GRP_IDX_W-1:0]]) == int'(part));
        case (op)
            OP_ASSIGN:
            begin
                if (mine)
                    return ST_OK;
                if (taken)
                    return ST_PERM;
                grp_taken[grp[GRP_IDX_W-1:0]] = 1'b1;
                grp_owner[grp[GRP_IDX_W-1:0]] = part[PART_W-1:0];
                return ST_OK;
            end
            OP_RELEASE:
            begin
                if (!mine)
                    return ST_PERM;
                grp_taken[grp[GRP_IDX_W-1:0]] = 1'b0;
                grp_owner[grp[GRP_IDX_W-1:0]] = '0;
                return ST_OK;
            end
            default:
                return mine ? ST_OK : ST_PERM;
        endcase
    endfunction

    // Drives the next transaction onto the request ports.
    task automatic present_next();
        logic [1:0] op;
        logic [7:0] grp;
        logic [7:0] part;
        int roll;
        if (issued_count < probes.size())
        begin
            op        = probes[issued_count].op;
            grp       = probes[issued_count].grp;
            part      = probes[issued_count].part;
            cur_typed = probes[issued_count].typed;
            cur_want  = probes[issued_count].want;
        end
        else
        begin
            cur_typed = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                op   = 2'($urandom_range(0, 3));
                grp  = 8'($urandom);
                part = 8'($urandom);
            end
            else if (roll < 12)
            begin
                op   = 2'($urandom_range(0, 2));
                grp  = 8'($urandom_range(1, NUM_GROUPS - 1));
                part = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(NUM_PARTITIONS, 255));
            end
            else
            begin
                op  = 2'($urandom_range(0, 2));
                grp = $urandom_range(0, 1) ? 8'($urandom_range(1, 6))
                                           : 8'($urandom_range(1, NUM_GROUPS - 1));
                if (grp_taken[grp[GRP_IDX_W-1:0]] && $urandom_range(0, 1))
                    part = 8'(grp_owner[grp[GRP_IDX_W-1:0]]);
                else
                    part = 8'($urandom_range(1, NUM_PARTITIONS - 1));
            end
        end
        req_type      <= op;
        group_num     <= grp;
        partition_num <= part;
        start         <= 1'b1;
        issued_count++;
    endtask

    initial
    begin
        add_probe(OP_CHECK,   8'd1,   8'd1,   1'b1, ST_PERM);
        add_probe(OP_ASSIGN,  8'd0,   8'd1,   1'b1, ST_INVAL);
        add_probe(OP_ASSIGN,  8'd64,  8'd1,   1'b1, ST_INVAL);
        add_probe(OP_ASSIGN,  8'd255, 8'd255, 1'b1, ST_INVAL);
        add_probe(OP_ASSIGN,  8'd1,   8'd0,   1'b1, ST_INVAL);
        add_probe(OP_ASSIGN,  8'd1,   8'd16,  1'b1, ST_INVAL);
        add_probe(OP_UNUSED,  8'd1,   8'd1,   1'b1, ST_INVAL);
        add_probe(OP_ASSIGN,  8'd1,   8'd1,   1'b1, ST_OK);
        add_probe(OP_ASSIGN,  8'd1,   8'd1,   1'b1, ST_OK);
        add_probe(OP_ASSIGN,  8'd1,   8'd2,   1'b1, ST_PERM);
        add_probe(OP_CHECK,   8'd1,   8'd1,   1'b1, ST_OK);
        add_probe(OP_CHECK,   8'd1,   8'd2,   1'b1, ST_PERM);
        add_probe(OP_RELEASE, 8'd1,   8'd2,   1'b1, ST_PERM);
        add_probe(OP_RELEASE, 8'd1,   8'd1,   1'b1, ST_OK);
        add_probe(OP_RELEASE, 8'd1,   8'd1,   1'b1, ST_PERM);
        add_probe(OP_ASSIGN,  8'd63,  8'd15,  1'b1, ST_OK);
        add_probe(OP_CHECK,   8'd63,  8'd15,  1'b1, ST_OK);
        add_probe(OP_RELEASE, 8'd63,  8'd15,  1'b1, ST_OK);
        add_probe(OP_ASSIGN,  8'd63,  8'd15,  1'b0, ST_OK);
        add_probe(OP_UNUSED,  8'd63,  8'd15,  1'b1, ST_INVAL);
        add_probe(OP_CHECK,   8'd63,  8'd14,  1'b0, ST_OK);
        add_probe(OP_ASSIGN,  8'd2,   8'd1,   1'b0, ST_OK);
        add_probe(OP_RELEASE, 8'd3,   8'd1,   1'b1, ST_PERM);
        add_probe(OP_ASSIGN,  8'd63,  8'd255, 1'b1, ST_INVAL);
        total_items = probes.size() + RANDOM_ITEMS;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_taken[g] = 1'b0;
            grp_owner[g] = '0;
        end
    end

    initial
    begin
        awaited_t due;
        bit accepted;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (!run_over)
        begin
            @(posedge clk);
            cycle_count++;
            if (done)
            begin
                if (awaited_status.size() == 0)
                begin
                    $display("%0t: result with no transaction pending: expected none, got %0d",
                             $time, status);
                    error_count++;
                end
                else
                begin
                    due = awaited_status.pop_front();
                    if (status !== due.status)
                    begin
                        $display("%0t: op %0d group %0d partition %0d: expected %0d, got %0d",
                                 $time, due.op, due.grp, due.part, due.status, status);
                        error_count++;
                    end
                end
            end
            accepted = start && !busy;
            if (accepted)
            begin
                due.op     = req_type;
                due.grp    = group_num;
                due.part   = partition_num;
                due.status = ownership_verdict(req_type, group_num, partition_num);
                if (cur_typed)
                    due.status = cur_want;
                awaited_status.push_back(due);
                accepted_count++;
                if (issued_count < total_items - CALM_TAIL && (accepted_count / 150) % 3 != 2 &&
                    $urandom_range(0, 2) == 0)
                    idle_left = $urandom_range(1, 8);
            end
            if (start && !accepted)
                ;
            else if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (issued_count < total_items)
                present_next();
            else
                start <= 1'b0;
            if (accepted_count == total_items && awaited_status.size() == 0)
            begin
                drain_count++;
                if (drain_count >= DRAIN_CYCLES)
                    run_over = 1'b1;
            end
            if (cycle_count >= CYCLE_LIMIT)
            begin
                timed_out = 1'b1;
                run_over  = 1'b1;
            end
        end
        if (timed_out)
            $display("TB_ERROR");
        else if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/gotb_pkg.sv
hdl/gotb_ctrl.sv
hdl/gotb_datapath.sv
hdl/group_ownership_table.sv
bench/group_ownership_table_test.sv
